### src/bgzfs_pkg.sv
// Shared types and constants for the BGZF block scanner.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps
`default_nettype none

package bgzfs_pkg;

   localparam int HEAD_CHECK_INTERVAL_DEF = 10000;
   localparam int MIN_BLOCK_BYTES_DEF     = 28;
   localparam int HEADER_BYTES            = 16;
   localparam int SIZE_LO_POS             = 16;
   localparam int SIZE_HI_POS             = 17;
   localparam int QUEUE_DEPTH             = 4;
   localparam int CSR_ADDR_W              = 4;

   localparam logic [1:0] REG_DEST_LIMIT = 2'd0;
   localparam logic [1:0] REG_SRC_BASE   = 2'd1;
   localparam logic [1:0] REG_DEST_BASE  = 2'd2;

   localparam logic KIND_BLOCK   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_HEADER  = 2'd1,
      ST_LIMIT   = 2'd2,
      ST_TRUNC   = 2'd3
   } status_type;

   localparam logic [7:0] GZ_HEAD [HEADER_BYTES] = '{
      8'h1f, 8'h8b, 8'h08, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'hff, 8'h06, 8'h00, 8'h42, 8'h43, 8'h02, 8'h00
   };

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] block_number;
      logic [31:0] src_offset;
      logic [16:0] src_length;
      logic [31:0] dest_offset;
      logic [31:0] dest_length;
      logic [31:0] stored_crc;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_type;

   // One queue entry: an optional block descriptor and an optional summary,
   // offsets relative to the configured bases.
   typedef struct packed {
      logic        desc_valid;
      logic [31:0] desc_number;
      logic [31:0] desc_start;
      logic [16:0] desc_length;
      logic [31:0] desc_dest;
      logic [31:0] desc_isize;
      logic [31:0] desc_crc;
      logic        sum_valid;
      logic [31:0] sum_count;
      logic [31:0] sum_start;
      logic [31:0] sum_dest;
      status_type  sum_status;
   } entry_type;

endpackage

`default_nettype wire

### src/bgzfs_front.sv
// Front part of the BGZF block scanner: takes bytes, tracks block state
// and queues descriptors and summaries. Depends on bgzfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgzfs_front #(
   parameter int HEAD_CHECK_INTERVAL = bgzfs_pkg::HEAD_CHECK_INTERVAL_DEF,
   parameter int MIN_BLOCK_BYTES     = bgzfs_pkg::MIN_BLOCK_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire bgzfs_pkg::req_type   req_data,
   output logic                      req_stall,
   input  wire logic [31:0]          dest_limit,
   input  wire logic                 q_full,
   output logic                      q_push,
   output bgzfs_pkg::entry_type      q_entry
);

   localparam int MOD_W = (HEAD_CHECK_INTERVAL > 1) ? $clog2(HEAD_CHECK_INTERVAL) : 1;
   localparam logic [MOD_W-1:0] MOD_LAST  = MOD_W'(HEAD_CHECK_INTERVAL - 1);
   localparam logic [MOD_W-1:0] MOD_CHECK = MOD_W'((HEAD_CHECK_INTERVAL == 1) ? 0 : 1);

   logic [16:0]           bib_ff, bib_in;
   logic [15:0]           bs_ff, bs_in;
   logic [31:0]           bstart_ff, bstart_in;
   logic [31:0]           dpos_ff, dpos_in;
   logic [31:0]           bcount_ff, bcount_in;
   logic [63:0]           shift_ff, shift_in;
   logic                  check_ff, check_in;
   logic                  stopped_ff, stopped_in;
   bgzfs_pkg::status_type stop_st_ff, stop_st_in;
   logic [MOD_W-1:0]      mod_ff, mod_in;

   logic                  take;
   logic [7:0]            b;
   logic [16:0]           pos;
   logic [15:0]           bs_cur;
   logic [16:0]           len;
   logic [63:0]           ts;
   logic [32:0]           dsum;
   logic [MOD_W-1:0]      mod_next;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;
   assign b         = req_data.data_byte;
   assign pos       = bib_ff;
   assign ts        = {b, shift_ff[63:8]};
   assign len       = {1'b0, bs_cur} + 17'd1;
   assign dsum      = {1'b0, dpos_ff} + {1'b0, ts[63:32]};

   always_comb begin
      if (pos == 17'(bgzfs_pkg::SIZE_LO_POS)) begin
         bs_cur = {8'h00, b};
      end else if (pos == 17'(bgzfs_pkg::SIZE_HI_POS)) begin
         bs_cur = {b, bs_ff[7:0]};
      end else begin
         bs_cur = bs_ff;
      end
   end

   always_comb begin
      if (bcount_ff == '1) begin
         mod_next = '0;
      end else if (mod_ff == MOD_LAST) begin
         mod_next = '0;
      end else begin
         mod_next = mod_ff + MOD_W'(1);
      end
   end

   always_comb begin
      bib_in     = bib_ff;
      bs_in      = bs_ff;
      bstart_in  = bstart_ff;
      dpos_in    = dpos_ff;
      bcount_in  = bcount_ff;
      shift_in   = shift_ff;
      check_in   = check_ff;
      stopped_in = stopped_ff;
      stop_st_in = stop_st_ff;
      mod_in     = mod_ff;
      q_entry    = '0;
      if (take) begin
         if (!stopped_ff) begin
            shift_in = ts;
            bs_in    = bs_cur;
            if (check_ff && pos < 17'(bgzfs_pkg::HEADER_BYTES) &&
                b != bgzfs_pkg::GZ_HEAD[pos[3:0]]) begin
               stopped_in = 1'b1;
               stop_st_in = bgzfs_pkg::ST_HEADER;
            end else if (pos == 17'(bgzfs_pkg::SIZE_HI_POS) &&
                         len < 17'(MIN_BLOCK_BYTES)) begin
               stopped_in = 1'b1;
               stop_st_in = bgzfs_pkg::ST_HEADER;
            end else if (pos >= 17'(bgzfs_pkg::SIZE_HI_POS) && pos == {1'b0, bs_cur}) begin
               if (dsum > {1'b0, dest_limit}) begin
                  stopped_in = 1'b1;
                  stop_st_in = bgzfs_pkg::ST_LIMIT;
               end else begin
                  q_entry.desc_valid  = 1'b1;
                  q_entry.desc_number = bcount_ff;
                  q_entry.desc_start  = bstart_ff;
                  q_entry.desc_length = len;
                  q_entry.desc_dest   = dpos_ff;
                  q_entry.desc_isize  = ts[63:32];
                  q_entry.desc_crc    = ts[31:0];
                  dpos_in   = dsum[31:0];
                  bstart_in = bstart_ff + {15'd0, len};
                  bcount_in = bcount_ff + 32'd1;
                  bib_in    = '0;
                  bs_in     = '0;
                  shift_in  = '0;
                  mod_in    = mod_next;
                  check_in  = (mod_next == MOD_CHECK);
               end
            end else begin
               bib_in = pos + 17'd1;
            end
         end
         if (req_data.final_byte) begin
            q_entry.sum_valid = 1'b1;
            q_entry.sum_count = bcount_in;
            q_entry.sum_start = bstart_in;
            q_entry.sum_dest  = dpos_in;
            if (stopped_in) begin
               q_entry.sum_status = stop_st_in;
            end else if (bib_in != '0) begin
               q_entry.sum_status = bgzfs_pkg::ST_TRUNC;
            end else begin
               q_entry.sum_status = bgzfs_pkg::ST_OK;
            end
            // start a fresh pass with the next byte
            bib_in     = '0;
            bs_in      = '0;
            bstart_in  = '0;
            dpos_in    = '0;
            bcount_in  = '0;
            shift_in   = '0;
            check_in   = 1'b1;
            stopped_in = 1'b0;
            stop_st_in = bgzfs_pkg::ST_OK;
            mod_in     = '0;
         end
      end
   end

   assign q_push = q_entry.desc_valid || q_entry.sum_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         bib_ff     <= '0;
         bs_ff      <= '0;
         bstart_ff  <= '0;
         dpos_ff    <= '0;
         bcount_ff  <= '0;
         shift_ff   <= '0;
         check_ff   <= 1'b1;
         stopped_ff <= 1'b0;
         stop_st_ff <= bgzfs_pkg::ST_OK;
         mod_ff     <= '0;
      end else begin
         bib_ff     <= bib_in;
         bs_ff      <= bs_in;
         bstart_ff  <= bstart_in;
         dpos_ff    <= dpos_in;
         bcount_ff  <= bcount_in;
         shift_ff   <= shift_in;
         check_ff   <= check_in;
         stopped_ff <= stopped_in;
         stop_st_ff <= stop_st_in;
         mod_ff     <= mod_in;
      end
   end

endmodule

`default_nettype wire

### src/bgzfs_queue.sv
// Short queue of scan entries between front and back of the scanner.
// Depends on bgzfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgzfs_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire bgzfs_pkg::entry_type  push_entry,
   input  wire logic                  pop,
   output bgzfs_pkg::entry_type       head,
   output logic                       full,
   output logic                       empty
);

   localparam int PTR_W = $clog2(bgzfs_pkg::QUEUE_DEPTH);

   bgzfs_pkg::entry_type slot_ff [bgzfs_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [PTR_W:0]       cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PTR_W+1)'(bgzfs_pkg::QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

### src/bgzfs_back.sv
// Back part of the BGZF block scanner: turns queue entries into results,
// adds the configured bases and holds the output register. Depends on bgzfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgzfs_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [31:0]           src_base,
   input  wire logic [31:0]           dest_base,
   input  wire bgzfs_pkg::entry_type  head,
   input  wire logic                  q_empty,
   output logic                       q_pop,
   output logic                       rsp_valid,
   output bgzfs_pkg::rsp_type         rsp_data,
   input  wire logic                  rsp_stall
);

   logic               rsp_valid_ff, rsp_valid_in;
   bgzfs_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic               phase_ff, phase_in;
   logic               load;
   logic               emit_desc;
   bgzfs_pkg::rsp_type next_rsp;

   assign load      = !q_empty && (!rsp_valid_ff || !rsp_stall);
   assign emit_desc = head.desc_valid && !phase_ff;

   always_comb begin
      next_rsp = '0;
      if (emit_desc) begin
         next_rsp.kind         = bgzfs_pkg::KIND_BLOCK;
         next_rsp.block_number = head.desc_number;
         next_rsp.src_offset   = src_base + head.desc_start;
         next_rsp.src_length   = head.desc_length;
         next_rsp.dest_offset  = dest_base + head.desc_dest;
         next_rsp.dest_length  = head.desc_isize;
         next_rsp.stored_crc   = head.desc_crc;
         next_rsp.status       = bgzfs_pkg::ST_OK;
         next_rsp.last_of_run  = !head.sum_valid;
      end else begin
         next_rsp.kind         = bgzfs_pkg::KIND_SUMMARY;
         next_rsp.block_number = head.sum_count;
         next_rsp.src_offset   = src_base + head.sum_start;
         next_rsp.src_length   = '0;
         next_rsp.dest_offset  = dest_base + head.sum_dest;
         next_rsp.dest_length  = head.sum_dest;
         next_rsp.stored_crc   = '0;
         next_rsp.status       = head.sum_status;
         next_rsp.last_of_run  = 1'b1;
      end
   end

   always_comb begin
      q_pop        = 1'b0;
      phase_in     = phase_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = next_rsp;
         // keep the entry for a second result when it also carries a summary
         if (emit_desc && head.sum_valid) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            q_pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### src/bgzf_block_scanner.sv
// BGZF block scanner: one compressed byte per cycle in while the queue is not
// full; the entry for a byte that causes a result is written to the queue and
// then to the rsp output register. A byte that ends a block and the pass gives
// two results from a single entry of the four-entry queue between the parts.
// Synchronous reset empties the queue and output, zeroes the configuration
// registers and scan counters, and arms the header check for the first block.
`timescale 1ns / 1ps
`default_nettype none

module bgzf_block_scanner #(
   parameter int HEAD_CHECK_INTERVAL = bgzfs_pkg::HEAD_CHECK_INTERVAL_DEF,
   parameter int MIN_BLOCK_BYTES     = bgzfs_pkg::MIN_BLOCK_BYTES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire bgzfs_pkg::req_type                    req_data,
   output logic                                       req_stall,
   output logic                                       rsp_valid,
   output bgzfs_pkg::rsp_type                         rsp_data,
   input  wire logic                                  rsp_stall,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [bgzfs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [31:0]                           pwdata,
   output logic [31:0]                                prdata,
   output logic                                       pready
);

   logic [31:0]          dest_limit_ff, dest_limit_in;
   logic [31:0]          src_base_ff, src_base_in;
   logic [31:0]          dest_base_ff, dest_base_in;
   logic                 csr_write;
   logic [1:0]           csr_index;

   logic                 q_full;
   logic                 q_empty;
   logic                 q_push;
   logic                 q_pop;
   bgzfs_pkg::entry_type q_entry;
   bgzfs_pkg::entry_type q_head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      dest_limit_in = dest_limit_ff;
      src_base_in   = src_base_ff;
      dest_base_in  = dest_base_ff;
      if (csr_write) begin
         unique case (csr_index)
            bgzfs_pkg::REG_DEST_LIMIT: dest_limit_in = pwdata;
            bgzfs_pkg::REG_SRC_BASE:   src_base_in   = pwdata;
            bgzfs_pkg::REG_DEST_BASE:  dest_base_in  = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bgzfs_pkg::REG_DEST_LIMIT: prdata = dest_limit_ff;
         bgzfs_pkg::REG_SRC_BASE:   prdata = src_base_ff;
         bgzfs_pkg::REG_DEST_BASE:  prdata = dest_base_ff;
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_limit_ff <= '0;
         src_base_ff   <= '0;
         dest_base_ff  <= '0;
      end else begin
         dest_limit_ff <= dest_limit_in;
         src_base_ff   <= src_base_in;
         dest_base_ff  <= dest_base_in;
      end
   end

   bgzfs_front #(
      .HEAD_CHECK_INTERVAL (HEAD_CHECK_INTERVAL),
      .MIN_BLOCK_BYTES     (MIN_BLOCK_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .dest_limit (dest_limit_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   bgzfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   bgzfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .src_base  (src_base_ff),
      .dest_base (dest_base_ff),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

`ifndef SYNTHESIS
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == bgzfs_pkg::KIND_SUMMARY |-> rsp_data.last_of_run)
      else $error("summary result not marked last of run");

   a_block_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == bgzfs_pkg::KIND_BLOCK |-> rsp_data.status == 2'd0)
      else $error("block descriptor with non-zero status");

   a_block_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == bgzfs_pkg::KIND_BLOCK
         |-> rsp_data.src_length >= 17'(MIN_BLOCK_BYTES))
      else $error("block descriptor shorter than the minimum block");

   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

### test/bgzf_scan_checker.sv
// Scoreboard for the BGZF block scanner: follows the register bus and both channels,
// predicts descriptors and summaries per accepted request and compares them in order.
// Depends on bgzfs_pkg for the request/response types, status codes and header bytes.
`timescale 1ns / 1ps

module bgzf_scan_checker
   import bgzfs_pkg::*;
#(
   parameter int HEAD_INTERVAL = HEAD_CHECK_INTERVAL_DEF,
   parameter int MIN_BLOCK     = MIN_BLOCK_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_type               req_data,
   input  logic                  req_stall,
   input  logic                  rsp_valid,
   input  rsp_type               rsp_data,
   input  logic                  rsp_stall,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    fail_count,
   output int                    records_due
);

   logic [31:0] limit_reg, src_base_reg, dest_base_reg;

   logic [16:0] pos_in_block;
   logic [15:0] size_field;
   logic [31:0] start_ofs, out_pos, blocks_done;
   logic [63:0] trailer;
   bit          check_head, halted;
   status_type  halt_code;

   rsp_type     due_records[$];

   task automatic clear_scan();
      pos_in_block = '0;
      size_field   = '0;
      start_ofs    = '0;
      out_pos      = '0;
      blocks_done  = '0;
      trailer      = '0;
      check_head   = 1'b1;
      halted       = 1'b0;
      halt_code    = ST_OK;
   endtask

   task automatic scan_byte(input req_type r);
      rsp_type     outs [2];
      int          n;
      logic [16:0] pos, blen;
      logic [31:0] isize, crc;
      n = 0;
      if (!halted) begin
         pos     = pos_in_block;
         trailer = {r.data_byte, trailer[63:8]};
         if (check_head && pos < HEADER_BYTES && r.data_byte != GZ_HEAD[pos[3:0]]) begin
            halted    = 1'b1;
            halt_code = ST_HEADER;
         end else begin
            if (pos == SIZE_LO_POS) size_field = {8'h00, r.data_byte};
            else if (pos == SIZE_HI_POS) size_field[15:8] = r.data_byte;
            blen = {1'b0, size_field} + 17'd1;
            if (pos == SIZE_HI_POS && blen < MIN_BLOCK) begin
               halted    = 1'b1;
               halt_code = ST_HEADER;
            end else if (pos >= SIZE_HI_POS && pos == {1'b0, size_field}) begin
               isize = trailer[63:32];
               crc   = trailer[31:0];
               // limit sum is taken at 33 bits, no wrap
               if ({1'b0, out_pos} + {1'b0, isize} > {1'b0, limit_reg}) begin
                  halted    = 1'b1;
                  halt_code = ST_LIMIT;
               end else begin
                  outs[n]              = '0;
                  outs[n].kind         = KIND_BLOCK;
                  outs[n].block_number = blocks_done;
                  outs[n].src_offset   = src_base_reg + start_ofs;
                  outs[n].src_length   = blen;
                  outs[n].dest_offset  = dest_base_reg + out_pos;
                  outs[n].dest_length  = isize;
                  outs[n].stored_crc   = crc;
                  outs[n].status       = ST_OK;
                  n++;
                  out_pos      = out_pos + isize;
                  start_ofs    = start_ofs + 32'(blen);
                  blocks_done  = blocks_done + 32'd1;
                  pos_in_block = '0;
                  size_field   = '0;
                  trailer      = '0;
                  check_head   = (blocks_done % HEAD_INTERVAL) == (1 % HEAD_INTERVAL);
               end
            end else begin
               pos_in_block = pos + 17'd1;
            end
         end
      end
      if (r.final_byte) begin
         outs[n]              = '0;
         outs[n].kind         = KIND_SUMMARY;
         outs[n].block_number = blocks_done;
         outs[n].src_offset   = src_base_reg + start_ofs;
         outs[n].dest_offset  = dest_base_reg + out_pos;
         outs[n].dest_length  = out_pos;
         outs[n].status       = halted ? halt_code : (pos_in_block != 0 ? ST_TRUNC : ST_OK);
         n++;
         clear_scan();
      end
      if (n > 0) outs[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) due_records.insert(due_records.size(), outs[i]);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         limit_reg     = '0;
         src_base_reg  = '0;
         dest_base_reg = '0;
         clear_scan();
         due_records.delete();
         fail_count    = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_DEST_LIMIT: limit_reg     = pwdata;
               REG_SRC_BASE:   src_base_reg  = pwdata;
               REG_DEST_BASE:  dest_base_reg = pwdata;
               default: ;
            endcase
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (due_records.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result %h", $realtime, rsp_data);
            end else begin
               want = due_records.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch (exp/got) kind %0d/%0d num %h/%h src %h/%h ",
                               "len %h/%h dest %h/%h dlen %h/%h crc %h/%h st %0d/%0d ",
                               "last %0d/%0d"}, $realtime,
                              want.kind, rsp_data.kind, want.block_number,
                              rsp_data.block_number, want.src_offset, rsp_data.src_offset,
                              want.src_length, rsp_data.src_length, want.dest_offset,
                              rsp_data.dest_offset, want.dest_length, rsp_data.dest_length,
                              want.stored_crc, rsp_data.stored_crc, want.status,
                              rsp_data.status, want.last_of_run, rsp_data.last_of_run);
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) scan_byte(req_data);
      end
      records_due = due_records.size();
   end

endmodule

### test/tb_bgzf_block_scanner.sv
// Top of the BGZF block scanner bench: builds compressed byte streams, drives the
// request, response and register ports, and reports the verdict.
// Depends on bgzfs_pkg, bgzf_block_scanner and bgzf_scan_checker.
`timescale 1ns / 1ps

module tb_bgzf_block_scanner;
   import bgzfs_pkg::*;

   localparam int HEAD_INTERVAL = 3;
   localparam int CYCLE_LIMIT   = 2_000_000;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_data  = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  rsp_stall = 1'b0;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int      fail_count, records_due;
   req_type stream_bytes[$];
   int      items_made = 0;
   int      cycle_count = 0;
   bit      send_gaps = 1'b1;
   bit      recv_gaps = 1'b1;
   bit      hold_go = 1'b0;
   logic    holding = 1'b0;

   bgzf_block_scanner #(.HEAD_CHECK_INTERVAL(HEAD_INTERVAL)) u_dut (
      .clock, .reset, .req_valid, .req_data, .req_stall, .rsp_valid, .rsp_data,
      .rsp_stall, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   bgzf_scan_checker #(.HEAD_INTERVAL(HEAD_INTERVAL)) u_checker (
      .clock, .reset, .req_valid, .req_data, .req_stall, .rsp_valid, .rsp_data,
      .rsp_stall, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .records_due
   );

   always #4 clock = ~clock;

   // advance to the next request only once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (stream_bytes.size() > 0 && !(send_gaps && $urandom_range(99) < 8)) begin
            req_valid <= 1'b1;
            req_data  <= stream_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= holding || (recv_gaps && $urandom_range(99) < 8);
   end

   // long receiver hold-off so the internal queue fills and the input stalls
   initial begin
      int held;
      wait (hold_go);
      @(posedge clock);
      holding <= 1'b1;
      for (held = 0; held < 600; held++) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL bgzf_block_scanner");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] b, input bit fin);
      req_type r;
      r.data_byte = b;
      r.final_byte = fin;
      stream_bytes.insert(stream_bytes.size(), r);
      items_made++;
   endtask

   // one block with size field size_val; keep cuts it short, bad_pos spoils a header byte
   task automatic append_block(input logic [15:0] size_val, input logic [31:0] isize,
                               input logic [31:0] crc, input int bad_pos, input int keep,
                               input bit close_pass);
      int          total, emit_count, i, t;
      logic [7:0]  b;
      req_type     r;
      total = int'(size_val) + 1;
      if (total < SIZE_HI_POS + 1) total = SIZE_HI_POS + 1;
      emit_count = (keep >= 0 && keep < total) ? keep : total;
      for (i = 0; i < emit_count; i++) begin
         t = i - (total - 8);
         if (i < HEADER_BYTES) begin
            b = GZ_HEAD[i];
            if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
         end else if (i == SIZE_LO_POS) b = size_val[7:0];
         else if (i == SIZE_HI_POS) b = size_val[15:8];
         else if (t >= 0 && t < 4) b = crc[8*t +: 8];
         else if (t >= 4) b = isize[8*(t-4) +: 8];
         else b = 8'($urandom);
         r.data_byte  = b;
         r.final_byte = close_pass && (i == emit_count - 1);
         stream_bytes.insert(stream_bytes.size(), r);
      end
      items_made += emit_count;
   endtask

   function automatic logic [31:0] pick_isize();
      case ($urandom_range(0, 19))
         0: return 32'd0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom_range(0, 3000);
      endcase
   endfunction

   function automatic logic [31:0] pick_base();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic append_pass(input int max_blocks, input bit tiny);
      int          nblk, ending, i, bad;
      logic [15:0] sz;
      bit          closed, halts;
      nblk   = $urandom_range(0, max_blocks);
      ending = $urandom_range(0, 9);
      closed = 1'b0;
      for (i = 0; i < nblk; i++) begin
         if (tiny) sz = 16'($urandom_range(27, 40));
         else if ($urandom_range(0, 9) == 0) sz = 16'($urandom_range(121, 1500));
         else sz = 16'($urandom_range(27, 120));
         if ($urandom_range(0, 24) == 0) sz = 16'($urandom_range(0, 26));
         bad    = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 15)) : -1;
         halts  = bad >= 0 || sz < 27;
         closed = (i == nblk - 1) && ending < 5;
         append_block(sz, pick_isize(), $urandom, bad, -1, closed);
         if (halts && !closed) break;
      end
      if (!closed) begin
         case (ending)
            5, 6: begin
               sz = 16'($urandom_range(27, 120));
               append_block(sz, pick_isize(), $urandom, -1, $urandom_range(1, sz), 1'b1);
            end
            7: push_byte(8'($urandom), 1'b1);
            default: begin
               repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
               push_byte(8'($urandom), 1'b1);
            end
         endcase
      end
   endtask

   // hold until every request is taken and every result has come back
   task automatic wait_drain();
      do @(negedge clock);
      while (stream_bytes.size() != 0 || req_valid || records_due != 0);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int phase_no, target, i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: one-byte pass, bad first byte, minimum block, short blocks, cut header
      csr_write(REG_DEST_LIMIT, 32'hFFFF_FFFF);
      csr_write(REG_SRC_BASE, 32'd0);
      csr_write(REG_DEST_BASE, 32'd0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h1F, 1'b1);
      append_block(16'd27, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1, -1, 1'b1);
      append_block(16'd0, 32'd0, 32'd0, -1, -1, 1'b1);
      append_block(16'd26, 32'd0, 32'd0, -1, -1, 1'b1);
      append_block(16'd27, 32'd0, 32'd0, -1, 5, 1'b1);
      append_block(16'd40, 32'd100, $urandom, -1, -1, 1'b0);
      append_block(16'd40, 32'd200, $urandom, 15, -1, 1'b0);
      push_byte(8'hA5, 1'b1);
      wait_drain();

      // zero limit with wrapping bases: only empty blocks fit
      csr_write(REG_DEST_LIMIT, 32'd0);
      csr_write(REG_SRC_BASE, 32'hFFFF_FFFF);
      csr_write(REG_DEST_BASE, 32'hFFFF_FFFF);
      append_block(16'd30, 32'd0, $urandom, -1, -1, 1'b0);
      append_block(16'd30, 32'd1, $urandom, -1, -1, 1'b0);
      push_byte(8'h5A, 1'b1);
      wait_drain();
      csr_write(REG_DEST_LIMIT, 32'd1000);
      append_block(16'd28, 32'd600, $urandom, -1, -1, 1'b0);
      append_block(16'd29, 32'd400, $urandom, -1, -1, 1'b0);
      append_block(16'd31, 32'd1, $urandom, -1, -1, 1'b1);
      wait_drain();

      // receiver hold-off over a run of small blocks near the minimum size
      csr_write(REG_DEST_LIMIT, 32'hFFFF_FFFF);
      hold_go = 1'b1;
      for (i = 0; i < 30; i++)
         append_block(16'($urandom_range(27, 32)), $urandom_range(0, 500), $urandom, -1, -1,
                      i == 29);
      wait_drain();

      phase_no = 0;
      while (items_made < 1700) begin
         phase_no++;
         case ($urandom_range(0, 3))
            0: csr_write(REG_DEST_LIMIT, 32'hFFFF_FFFF);
            1: csr_write(REG_DEST_LIMIT, $urandom_range(0, 20000));
            2: csr_write(REG_DEST_LIMIT, $urandom);
            default: csr_write(REG_DEST_LIMIT, 32'd0);
         endcase
         csr_write(REG_SRC_BASE, pick_base());
         csr_write(REG_DEST_BASE, pick_base());
         send_gaps = (phase_no != 3);
         recv_gaps = (phase_no != 3);
         target = items_made + 150;
         while (items_made < target) append_pass(6, phase_no % 4 == 1);
         wait_drain();
      end
      send_gaps = 1'b1;
      recv_gaps = 1'b1;

      // largest size field the block allows, cut short after the header
      csr_write(REG_DEST_LIMIT, 32'hFFFF_FFFF);
      append_block(16'hFFFF, pick_isize(), $urandom, -1, 40, 1'b1);
      wait_drain();

      if (fail_count == 0)
         $display("PASS bgzf_block_scanner");
      else
         $display("FAIL bgzf_block_scanner");
      $finish;
   end

endmodule
